// ===== hw/rtl/bdr_pkg.sv =====
// Package with the event, button and direction codes of the button direction resolver.
package bdr_pkg;

    localparam int unsigned REQ_W = 2;
    localparam int unsigned BTN_W = 3;
    localparam int unsigned DIR_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 2'd0,
        REQ_PRESS   = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_QUIT    = 2'd3
    } req_type_t;

    typedef enum logic [BTN_W-1:0] {
        BTN_UP     = 3'd0,
        BTN_DOWN   = 3'd1,
        BTN_LEFT   = 3'd2,
        BTN_RIGHT  = 3'd3,
        BTN_ACTION = 3'd4,
        BTN_JUMP   = 3'd5,
        BTN_PAUSE  = 3'd6,
        BTN_STEP   = 3'd7
    } button_t;

    typedef logic [DIR_W-1:0] dir_t;

    localparam dir_t DIR_NONE  = 2'd0;
    localparam dir_t DIR_LEFT  = 2'd1;
    localparam dir_t DIR_RIGHT = 2'd2;
    localparam dir_t DIR_UP    = 2'd1;
    localparam dir_t DIR_DOWN  = 2'd2;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } held_t;

    typedef struct packed {
        logic released;
        logic level;
        logic pressed;
    } btn_flags_t;

endpackage

// ===== hw/rtl/bdr_req_if.sv =====
// Handshake channel that carries one controller event.
interface bdr_req_if;
    import bdr_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [BTN_W-1:0] button;

    modport source (output valid, output req_type, output button, input ready);
    modport sink (input valid, input req_type, input button, output ready);
endinterface

// ===== hw/rtl/bdr_res_if.sv =====
// Handshake channel that carries the resolved controller state after one event.
interface bdr_res_if;
    import bdr_pkg::*;

    logic             valid;
    logic             ready;
    logic [DIR_W-1:0] horiz_dir;
    logic [DIR_W-1:0] vert_dir;
    logic [DIR_W-1:0] prev_horiz_dir;
    logic [DIR_W-1:0] prev_vert_dir;
    logic             action_edge_down;
    logic             action_level;
    logic             action_edge_up;
    logic             jump_edge_down;
    logic             jump_level;
    logic             jump_edge_up;
    logic             is_paused;
    logic             quit_seen;

    modport source (
        output valid, output horiz_dir, output vert_dir, output prev_horiz_dir,
        output prev_vert_dir, output action_edge_down, output action_level,
        output action_edge_up, output jump_edge_down, output jump_level,
        output jump_edge_up, output is_paused, output quit_seen, input ready
    );
    modport sink (
        input valid, input horiz_dir, input vert_dir, input prev_horiz_dir,
        input prev_vert_dir, input action_edge_down, input action_level,
        input action_edge_up, input jump_edge_down, input jump_level,
        input jump_edge_up, input is_paused, input quit_seen, output ready
    );
endinterface

// ===== hw/rtl/button_direction_resolver_unit.sv =====
// Top level of the button direction resolver: event register, state update and result register.
// Events enter the event register; results are presented from the result register.
// Throughput: one event per cycle while results are taken; event and result registers each hold
// one transaction, so a stalled result still lets one more event be taken before input stalls.
// Reset: asynchronous active-low reset clears all directions, flags and both valid bits.
module button_direction_resolver_unit
    import bdr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bdr_req_if.sink   req,
    bdr_res_if.source res
);

    logic             s1_valid_reg;
    logic [REQ_W-1:0] s1_type_reg;
    logic [BTN_W-1:0] s1_button_reg;
    logic             s1_advance;

    dir_t       horiz_now_reg, horiz_now_next;
    dir_t       vert_now_reg, vert_now_next;
    dir_t       horiz_prev_reg, horiz_prev_next;
    dir_t       vert_prev_reg, vert_prev_next;
    held_t      held_reg, held_next;
    btn_flags_t action_reg, action_next;
    btn_flags_t jump_reg, jump_next;
    logic       pause_reg, pause_next;
    logic       step_reg, step_next;
    logic       quit_reg, quit_next;
    logic       out_valid_reg;

    assign s1_advance = !out_valid_reg || res.ready;
    assign req.ready  = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_type_reg   <= req.req_type;
            s1_button_reg <= req.button;
        end
    end

    always_comb
    begin
        horiz_now_next  = horiz_now_reg;
        vert_now_next   = vert_now_reg;
        horiz_prev_next = horiz_prev_reg;
        vert_prev_next  = vert_prev_reg;
        held_next       = held_reg;
        action_next     = action_reg;
        jump_next       = jump_reg;
        pause_next      = pause_reg;
        step_next       = step_reg;
        quit_next       = quit_reg;
        case (req_type_t'(s1_type_reg))
            REQ_TICK:
            begin
                if (!pause_reg)
                begin
                    horiz_prev_next      = horiz_now_reg;
                    vert_prev_next       = vert_now_reg;
                    action_next.pressed  = 1'b0;
                    action_next.released = 1'b0;
                    jump_next.pressed    = 1'b0;
                    jump_next.released   = 1'b0;
                end
                if (step_reg)
                begin
                    pause_next = 1'b1;
                    step_next  = 1'b0;
                end
            end
            REQ_PRESS:
            begin
                case (button_t'(s1_button_reg))
                    BTN_UP:
                    begin
                        vert_now_next = DIR_UP;
                        held_next.up  = 1'b1;
                    end
                    BTN_DOWN:
                    begin
                        vert_now_next  = DIR_DOWN;
                        held_next.down = 1'b1;
                    end
                    BTN_LEFT:
                    begin
                        horiz_now_next = DIR_LEFT;
                        held_next.left = 1'b1;
                    end
                    BTN_RIGHT:
                    begin
                        horiz_now_next  = DIR_RIGHT;
                        held_next.right = 1'b1;
                    end
                    BTN_ACTION: action_next = '{released: 1'b0, level: 1'b1, pressed: 1'b1};
                    BTN_JUMP:   jump_next   = '{released: 1'b0, level: 1'b1, pressed: 1'b1};
                    BTN_PAUSE:  pause_next  = !pause_reg;
                    default:
                    begin
                        if (pause_reg)
                        begin
                            pause_next = 1'b0;
                            step_next  = 1'b1;
                        end
                    end
                endcase
            end
            REQ_RELEASE:
            begin
                case (button_t'(s1_button_reg))
                    BTN_UP:
                    begin
                        vert_now_next = held_reg.down ? DIR_DOWN : DIR_NONE;
                        held_next.up  = 1'b0;
                    end
                    BTN_DOWN:
                    begin
                        vert_now_next  = held_reg.up ? DIR_UP : DIR_NONE;
                        held_next.down = 1'b0;
                    end
                    BTN_LEFT:
                    begin
                        horiz_now_next = held_reg.right ? DIR_RIGHT : DIR_NONE;
                        held_next.left = 1'b0;
                    end
                    BTN_RIGHT:
                    begin
                        horiz_now_next  = held_reg.left ? DIR_LEFT : DIR_NONE;
                        held_next.right = 1'b0;
                    end
                    BTN_ACTION: action_next = '{released: 1'b1, level: 1'b0, pressed: 1'b0};
                    BTN_JUMP:   jump_next   = '{released: 1'b1, level: 1'b0, pressed: 1'b0};
                    default:    ;
                endcase
            end
            default: quit_next = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horiz_now_reg  <= DIR_NONE;
            vert_now_reg   <= DIR_NONE;
            horiz_prev_reg <= DIR_NONE;
            vert_prev_reg  <= DIR_NONE;
            held_reg       <= '0;
            action_reg     <= '0;
            jump_reg       <= '0;
            pause_reg      <= 1'b0;
            step_reg       <= 1'b0;
            quit_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                horiz_now_reg  <= horiz_now_next;
                vert_now_reg   <= vert_now_next;
                horiz_prev_reg <= horiz_prev_next;
                vert_prev_reg  <= vert_prev_next;
                held_reg       <= held_next;
                action_reg     <= action_next;
                jump_reg       <= jump_next;
                pause_reg      <= pause_next;
                step_reg       <= step_next;
                quit_reg       <= quit_next;
            end
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.horiz_dir        = horiz_now_reg;
    assign res.vert_dir         = vert_now_reg;
    assign res.prev_horiz_dir   = horiz_prev_reg;
    assign res.prev_vert_dir    = vert_prev_reg;
    assign res.action_edge_down = action_reg.pressed;
    assign res.action_level     = action_reg.level;
    assign res.action_edge_up   = action_reg.released;
    assign res.jump_edge_down   = jump_reg.pressed;
    assign res.jump_level       = jump_reg.level;
    assign res.jump_edge_up     = jump_reg.released;
    assign res.is_paused        = pause_reg;
    assign res.quit_seen        = quit_reg;

    // A resolved direction always belongs to a button that is still held.
    a_horiz_held: assert property (@(posedge clk) disable iff (!rst_n)
        (horiz_now_reg != DIR_LEFT || held_reg.left)
        && (horiz_now_reg != DIR_RIGHT || held_reg.right)
        && (vert_now_reg != DIR_UP || held_reg.up)
        && (vert_now_reg != DIR_DOWN || held_reg.down))
        else $error("resolved direction without its button held");

    a_edge_level: assert property (@(posedge clk) disable iff (!rst_n)
        (!action_reg.pressed || action_reg.level)
        && (!action_reg.released || !action_reg.level)
        && (!jump_reg.pressed || jump_reg.level)
        && (!jump_reg.released || !jump_reg.level))
        else $error("edge flag disagrees with level flag");

    a_quit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        quit_reg |=> quit_reg)
        else $error("quit flag cleared without reset");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && out_valid_reg && !res.ready))
        else $error("event channel stalled while a register was free");

endmodule

// ===== tb/button_direction_resolver_unit_checker.sv =====
// Checker that predicts the resolved controller state for each event and compares every result.
module button_direction_resolver_unit_checker
    import bdr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bdr_req_if   req,
    bdr_res_if   res,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        dir_t       horiz;
        dir_t       vert;
        dir_t       horiz_prev;
        dir_t       vert_prev;
        held_t      held;
        btn_flags_t action;
        btn_flags_t jump;
        logic       paused;
        logic       step_once;
        logic       quit;
    } ctrl_state_t;

    ctrl_state_t ctrl_state = '0;
    ctrl_state_t want;
    ctrl_state_t expected_states[$];
    int          mismatches = 0;
    int          waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    function automatic ctrl_state_t resolve_event(ctrl_state_t s, req_type_t kind,
                                                  button_t btn);
        ctrl_state_t n;
        n = s;
        case (kind)
            REQ_TICK:
            begin
                if (!s.paused)
                begin
                    n.horiz_prev      = s.horiz;
                    n.vert_prev       = s.vert;
                    n.action.pressed  = 1'b0;
                    n.action.released = 1'b0;
                    n.jump.pressed    = 1'b0;
                    n.jump.released   = 1'b0;
                end
                if (s.step_once)
                begin
                    n.paused    = 1'b1;
                    n.step_once = 1'b0;
                end
            end
            REQ_PRESS:
            begin
                case (btn)
                    BTN_UP:
                    begin
                        n.vert    = DIR_UP;
                        n.held.up = 1'b1;
                    end
                    BTN_DOWN:
                    begin
                        n.vert      = DIR_DOWN;
                        n.held.down = 1'b1;
                    end
                    BTN_LEFT:
                    begin
                        n.horiz     = DIR_LEFT;
                        n.held.left = 1'b1;
                    end
                    BTN_RIGHT:
                    begin
                        n.horiz      = DIR_RIGHT;
                        n.held.right = 1'b1;
                    end
                    BTN_ACTION:
                    begin
                        n.action.pressed  = 1'b1;
                        n.action.level    = 1'b1;
                        n.action.released = 1'b0;
                    end
                    BTN_JUMP:
                    begin
                        n.jump.pressed  = 1'b1;
                        n.jump.level    = 1'b1;
                        n.jump.released = 1'b0;
                    end
                    BTN_PAUSE:
                    begin
                        n.paused = !s.paused;
                    end
                    default:
                    begin
                        if (s.paused)
                        begin
                            n.paused    = 1'b0;
                            n.step_once = 1'b1;
                        end
                    end
                endcase
            end
            REQ_RELEASE:
            begin
                case (btn)
                    BTN_UP:
                    begin
                        n.vert    = s.held.down ? DIR_DOWN : DIR_NONE;
                        n.held.up = 1'b0;
                    end
                    BTN_DOWN:
                    begin
                        n.vert      = s.held.up ? DIR_UP : DIR_NONE;
                        n.held.down = 1'b0;
                    end
                    BTN_LEFT:
                    begin
                        n.horiz     = s.held.right ? DIR_RIGHT : DIR_NONE;
                        n.held.left = 1'b0;
                    end
                    BTN_RIGHT:
                    begin
                        n.horiz      = s.held.left ? DIR_LEFT : DIR_NONE;
                        n.held.right = 1'b0;
                    end
                    BTN_ACTION:
                    begin
                        n.action.pressed  = 1'b0;
                        n.action.level    = 1'b0;
                        n.action.released = 1'b1;
                    end
                    BTN_JUMP:
                    begin
                        n.jump.pressed  = 1'b0;
                        n.jump.level    = 1'b0;
                        n.jump.released = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                n.quit = 1'b1;
            end
        endcase
        return n;
    endfunction

    task automatic check_field(string name, int unsigned expected_value,
                               int unsigned actual_value);
        if (expected_value != actual_value)
        begin
            $error("%s: expected %0d, actual %0d", name, expected_value, actual_value);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_state = '0;
            expected_states.delete();
            waiting = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_states.size() == 0)
                begin
                    $error("result transaction with no expected state waiting");
                    mismatches++;
                end
                else
                begin
                    want = expected_states.pop_front();
                    check_field("horiz_dir", want.horiz, res.horiz_dir);
                    check_field("vert_dir", want.vert, res.vert_dir);
                    check_field("prev_horiz_dir", want.horiz_prev, res.prev_horiz_dir);
                    check_field("prev_vert_dir", want.vert_prev, res.prev_vert_dir);
                    check_field("action_edge_down", want.action.pressed, res.action_edge_down);
                    check_field("action_level", want.action.level, res.action_level);
                    check_field("action_edge_up", want.action.released, res.action_edge_up);
                    check_field("jump_edge_down", want.jump.pressed, res.jump_edge_down);
                    check_field("jump_level", want.jump.level, res.jump_level);
                    check_field("jump_edge_up", want.jump.released, res.jump_edge_up);
                    check_field("is_paused", want.paused, res.is_paused);
                    check_field("quit_seen", want.quit, res.quit_seen);
                end
            end
            if (req.valid && req.ready)
            begin
                ctrl_state = resolve_event(ctrl_state, req_type_t'(req.req_type),
                                           button_t'(req.button));
                expected_states.push_back(ctrl_state);
            end
            waiting = expected_states.size();
        end
    end

endmodule

// ===== tb/button_direction_resolver_unit_tb.sv =====
// Top of the button direction resolver testbench: clock, reset, event stimulus and verdict.
module button_direction_resolver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bdr_pkg::*;

    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_EVENTS   = 100;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    int         fail_count;
    int         pending;
    int         send_idle_level = 0;
    int         recv_stall_level = 0;
    int         quiet_cycles = 0;
    logic [5:0] held_mask = '0;

    bdr_req_if req_ch();
    bdr_res_if res_ch();

    button_direction_resolver_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    button_direction_resolver_unit_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_event(req_type_t kind, button_t btn);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.button   <= btn;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        if (send_idle_level != 0 && $urandom_range(0, 9) < send_idle_level)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic send_random_event();
        int unsigned pick;
        int unsigned slot;
        req_type_t   kind;
        button_t     btn;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            kind = REQ_TICK;
            btn  = button_t'($urandom_range(0, 7));
        end
        else if (pick < 68)
        begin
            kind = REQ_PRESS;
            slot = $urandom_range(0, 15);
            if (slot < 12)
                btn = button_t'(slot % 6);
            else if (slot < 14)
                btn = BTN_PAUSE;
            else
                btn = BTN_STEP;
        end
        else if (pick < 99)
        begin
            kind = REQ_RELEASE;
            if (held_mask != '0 && $urandom_range(0, 3) != 0)
            begin
                slot = $urandom_range(0, 5);
                while (!held_mask[slot[2:0]])
                    slot = $urandom_range(0, 5);
                btn = button_t'(slot);
            end
            else
            begin
                btn = button_t'($urandom_range(0, 7));
            end
        end
        else
        begin
            kind = REQ_QUIT;
            btn  = button_t'($urandom_range(0, 7));
        end
        if (btn <= BTN_JUMP && kind == REQ_PRESS)
            held_mask[btn] = 1'b1;
        if (btn <= BTN_JUMP && kind == REQ_RELEASE)
            held_mask[btn] = 1'b0;
        send_event(kind, btn);
    endtask

    initial
    begin
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (recv_stall_level != 0 && $urandom_range(0, 9) < recv_stall_level)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_TICK;
        req_ch.button   <= BTN_UP;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_event(REQ_TICK, BTN_UP);
        send_event(REQ_PRESS, BTN_UP);
        send_event(REQ_PRESS, BTN_DOWN);
        send_event(REQ_RELEASE, BTN_DOWN);
        send_event(REQ_RELEASE, BTN_UP);
        send_event(REQ_PRESS, BTN_LEFT);
        send_event(REQ_PRESS, BTN_RIGHT);
        send_event(REQ_RELEASE, BTN_LEFT);
        send_event(REQ_RELEASE, BTN_RIGHT);
        send_event(REQ_RELEASE, BTN_UP);
        send_event(REQ_PRESS, BTN_ACTION);
        send_event(REQ_PRESS, BTN_ACTION);
        send_event(REQ_TICK, BTN_ACTION);
        send_event(REQ_RELEASE, BTN_ACTION);
        send_event(REQ_PRESS, BTN_JUMP);
        send_event(REQ_RELEASE, BTN_JUMP);
        send_event(REQ_TICK, BTN_STEP);
        send_event(REQ_PRESS, BTN_PAUSE);
        send_event(REQ_TICK, BTN_STEP);
        send_event(REQ_PRESS, BTN_STEP);
        send_event(REQ_TICK, BTN_PAUSE);
        send_event(REQ_RELEASE, BTN_PAUSE);
        send_event(REQ_RELEASE, BTN_STEP);
        send_event(REQ_PRESS, BTN_PAUSE);
        send_event(REQ_PRESS, BTN_STEP);
        send_event(REQ_QUIT, BTN_STEP);
        pause_until_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == RANDOM_PHASES - 1)
            begin
                send_idle_level  = 0;
                recv_stall_level = 0;
            end
            else
            begin
                send_idle_level  = $urandom_range(0, 4);
                recv_stall_level = $urandom_range(0, 4);
            end
            for (int i = 0; i < PHASE_EVENTS; i++)
                send_random_event();
            pause_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
